// ===== rtl/lfsc_pkg.sv =====
// Shared types and constants for the loop frame serial codec.
// No dependencies; used by the channel interfaces and the top level.
package lfsc_pkg;

    localparam int FRAME_W = 11;
    localparam int BYTE_W  = 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    localparam logic [BYTE_W-1:0] ACK_BYTE = 8'd13;

    typedef enum logic [1:0] {
        REQ_RX_BYTE = 2'd0,
        REQ_SEND    = 2'd1,
        REQ_CMD     = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_BYTE  = 1'b1
    } res_kind_t;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] frame_out;
        logic [BYTE_W-1:0]  tx_byte;
        logic               last;
    } result_t;

endpackage

// ===== rtl/lfsc_req_if.sv =====
// Input item channel of the loop frame serial codec: valid/ready plus payload.
// Depends on lfsc_pkg for field widths.
interface lfsc_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [lfsc_pkg::BYTE_W-1:0] rx_byte;
    logic [lfsc_pkg::FRAME_W-1:0] frame_in;

    modport source (output valid, output req_type, output rx_byte, output frame_in,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input frame_in,
                    output ready);
endinterface

// ===== rtl/lfsc_res_if.sv =====
// Result item channel of the loop frame serial codec: valid/ready plus payload.
// Depends on lfsc_pkg for field widths.
interface lfsc_res_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [lfsc_pkg::FRAME_W-1:0] frame_out;
    logic [lfsc_pkg::BYTE_W-1:0]  tx_byte;
    logic                         last;

    modport source (output valid, output kind, output frame_out, output tx_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input frame_out, input tx_byte,
                    input last, output ready);
endinterface

// ===== rtl/loop_frame_serial_codec_unit.sv =====
// Top level of the loop frame serial codec.
// Depends on lfsc_pkg, lfsc_req_if and lfsc_res_if.
//
// Converts 11-bit loop frames to and from 7/8-bit serial bytes. An item is
// decoded or encoded in the cycle it is accepted and its results (zero, one
// or two) go into a four-entry result queue; the shared last-high and format
// registers update at that same edge. An item is accepted in any cycle the
// queue has room for two more results, so items with no or one result can
// stream at one per cycle while the result side keeps taking them. The queue
// drains one result per cycle while res.ready is high, and a send that emits
// both a high and a low byte puts two results into it. The first result is
// at the queue head on the cycle after acceptance when the queue was empty.
module loop_frame_serial_codec_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    lfsc_req_if.sink   req,
    lfsc_res_if.source res
);
    import lfsc_pkg::*;

    logic               ack_enable_reg;
    logic [BYTE_W-1:0]  last_high_reg, last_high_next;
    logic               eight_bit_reg, eight_bit_next;

    result_t            queue_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic               in_fire, out_fire;
    logic [1:0]         n_new;
    result_t            res0, res1;

    logic [BYTE_W-1:0]  hi_enc, lo_enc, hi_ref;
    logic [FRAME_W-1:0] frame_dec;

    assign req.ready = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_fire   = req.valid && req.ready;
    assign out_fire  = res.valid && res.ready;

    always_comb
    begin
        if (eight_bit_reg)
        begin
            hi_enc = {3'b001, req.frame_in[10:7], 1'b0};
            lo_enc = {1'b1, req.frame_in[6:0]};
        end
        else
        begin
            hi_enc = {3'b001, req.frame_in[10:6]};
            lo_enc = {2'b01, req.frame_in[5:0]};
        end
        // command frames compare against a cleared last-high
        hi_ref = (req.req_type == REQ_CMD) ? '0 : last_high_reg;

        if (req.rx_byte[7])
            frame_dec = {last_high_reg[4:1], req.rx_byte[6:0]};
        else
            frame_dec = {last_high_reg[4:0], req.rx_byte[5:0]};
    end

    always_comb
    begin
        last_high_next = last_high_reg;
        eight_bit_next = eight_bit_reg;
        n_new          = 2'd0;
        res0           = '{kind: KIND_BYTE, frame_out: '0, tx_byte: '0, last: 1'b1};
        res1           = res0;

        case (req.req_type)
            REQ_RX_BYTE:
            begin
                if (req.rx_byte[7:6] == 2'b00)
                begin
                    if (req.rx_byte[5])
                    begin
                        last_high_next = req.rx_byte;
                        if (ack_enable_reg)
                        begin
                            n_new        = 2'd1;
                            res0.tx_byte = ACK_BYTE;
                        end
                    end
                end
                else
                begin
                    eight_bit_next = req.rx_byte[7];
                    n_new          = 2'd1;
                    res0.kind      = KIND_FRAME;
                    res0.frame_out = frame_dec;
                end
            end
            REQ_SEND, REQ_CMD:
            begin
                last_high_next = hi_ref;
                if (hi_enc != hi_ref)
                begin
                    last_high_next = hi_enc;
                    n_new          = 2'd2;
                    res0.tx_byte   = hi_enc;
                    res0.last      = 1'b0;
                    res1.tx_byte   = lo_enc;
                end
                else
                begin
                    n_new        = 2'd1;
                    res0.tx_byte = lo_enc;
                end
            end
            default:
            begin
                n_new = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_enable_reg <= 1'b0;
            last_high_reg  <= '0;
            eight_bit_reg  <= 1'b1;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                ack_enable_reg <= cfg_wdata;
            if (in_fire)
            begin
                last_high_reg <= last_high_next;
                eight_bit_reg <= eight_bit_next;
                wr_ptr_reg    <= wr_ptr_reg + QPTR_W'(n_new);
            end
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (in_fire ? QCNT_W'(n_new) : '0)
                         - QCNT_W'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && n_new != 2'd0)
            queue_mem[wr_ptr_reg] <= res0;
        if (in_fire && n_new == 2'd2)
            queue_mem[wr_ptr_reg + 1'b1] <= res1;
    end

    assign res.valid     = (count_reg != '0);
    assign res.kind      = queue_mem[rd_ptr_reg].kind;
    assign res.frame_out = queue_mem[rd_ptr_reg].frame_out;
    assign res.tx_byte   = queue_mem[rd_ptr_reg].tx_byte;
    assign res.last      = queue_mem[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_room_for_two: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> count_reg <= QCNT_W'(QDEPTH))
        else $error("accepted item overflowed result queue");

    a_partner_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> count_reg >= QCNT_W'(2))
        else $error("non-final result without its final partner queued");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule
